[design/htlp_pkg.sv]
// ----------------------------------------------------------------------------
// htlp_pkg
// shared constants and types for the linear probing hash table
// ----------------------------------------------------------------------------
package htlp_pkg;

  localparam int TableDepth  = 256;
  localparam int SlotBits    = 8;
  localparam int CapBits     = 9;
  localparam int KeyBits     = 64;
  localparam int LenBits     = 4;
  localparam int OffsetBits  = 40;
  localparam int StatusBits  = 3;
  localparam int HashBits    = 32;
  localparam int EntryBits   = KeyBits + LenBits + OffsetBits;

  localparam logic [HashBits-1:0] DjbSeed = 32'd5381;
  localparam logic [LenBits-1:0]  MaxKeyBytes = 4'd8;
  localparam logic [CapBits-1:0]  CapReset = 9'd256;

  localparam logic [StatusBits-1:0] ST_INSERTED = 3'd0;
  localparam logic [StatusBits-1:0] ST_UPDATED  = 3'd1;
  localparam logic [StatusBits-1:0] ST_HIT      = 3'd2;
  localparam logic [StatusBits-1:0] ST_MISS     = 3'd3;
  localparam logic [StatusBits-1:0] ST_FULL     = 3'd4;

  localparam logic ACT_PUT = 1'b0;
  localparam logic ACT_GET = 1'b1;

  typedef struct packed {
    logic [KeyBits-1:0]    key;
    logic [LenBits-1:0]    len;
    logic [OffsetBits-1:0] offset;
  } entry_t;

  typedef struct packed {
    logic                en;
    logic [SlotBits-1:0] addr;
    logic                occ_only;
    entry_t              data;
  } wr_req_t;

endpackage

[design/htlp_hash.sv]
// ----------------------------------------------------------------------------
// htlp_hash
// djb2 over the key, one byte a cycle, then modulo by the capacity
// through restoring division, one quotient bit a cycle
// ----------------------------------------------------------------------------
module htlp_hash (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [htlp_pkg::KeyBits-1:0] key,
  input  logic [htlp_pkg::LenBits-1:0] len,
  input  logic [htlp_pkg::CapBits-1:0] cap,
  output logic                       done,
  output logic [htlp_pkg::SlotBits-1:0] home
);
  import htlp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HASH = 2'd1;
  localparam logic [1:0] S_MOD  = 2'd2;

  logic [1:0]          state;
  logic [HashBits-1:0] h;
  logic [KeyBits-1:0]  kshift;
  logic [LenBits-1:0]  left;
  logic [CapBits-1:0]  rem;
  logic [5:0]          bitn;
  logic [CapBits:0]    trial;

  assign trial = {rem, h[HashBits-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            h      <= DjbSeed;
            kshift <= key;
            left   <= len;
            state  <= S_HASH;
          end
        end
        S_HASH: begin
          if (left == '0) begin
            rem   <= '0;
            bitn  <= 6'(HashBits);
            state <= S_MOD;
          end else begin
            h      <= (h << 5) + h + {24'd0, kshift[7:0]};
            kshift <= kshift >> 8;
            left   <= left - 1'b1;
          end
        end
        S_MOD: begin
          if (trial >= {1'b0, cap}) begin
            rem <= CapBits'(trial - {1'b0, cap});
          end else begin
            rem <= trial[CapBits-1:0];
          end
          h    <= h << 1;
          bitn <= bitn - 1'b1;
          if (bitn == 6'd1) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign home = rem[SlotBits-1:0];

endmodule

[design/htlp_store.sv]
// ----------------------------------------------------------------------------
// htlp_store
// slot memory with registered read, occupied bits in flops cleared at reset
// ----------------------------------------------------------------------------
module htlp_store (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [htlp_pkg::SlotBits-1:0] rd_addr,
  output logic                          rd_occ,
  output htlp_pkg::entry_t              rd_data,
  input  htlp_pkg::wr_req_t             wr
);
  import htlp_pkg::*;

  entry_t              mem [TableDepth];
  logic [TableDepth-1:0] occ;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      if (wr.occ_only) begin
        mem[wr.addr].offset <= wr.data.offset;
      end else begin
        mem[wr.addr] <= wr.data;
      end
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ    <= '0;
      rd_occ <= 1'b0;
    end else begin
      if (wr.en) begin
        occ[wr.addr] <= 1'b1;
      end
      rd_occ <= occ[rd_addr];
    end
  end

endmodule

[design/hash_table_linear_probe.sv]
// ----------------------------------------------------------------------------
// hash_table_linear_probe
// djb2 keyed open-addressing table with linear probing
// ----------------------------------------------------------------------------
// channel  dir  handshake      payload
// in       in   valid / stall  action, key_bytes, key_length, new_offset
// out      out  valid / stall  status, found_offset
// cfg      in   valid / ready  capacity_in_use
//
// one item at a time: the key is hashed, then reduced modulo the capacity;
// each probed slot is then read and compared on the single read port of the
// slot memory (one more read state sees a full table), then the result is loaded.
// reset clears the occupied bits at once; no clearing pass.
// a stalled result stays in the output register; a new beat is taken then.
// ----------------------------------------------------------------------------
module hash_table_linear_probe (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            action,
  input  logic [htlp_pkg::KeyBits-1:0]    key_bytes,
  input  logic [htlp_pkg::LenBits-1:0]    key_length,
  input  logic [htlp_pkg::OffsetBits-1:0] new_offset,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [htlp_pkg::StatusBits-1:0] status,
  output logic [htlp_pkg::OffsetBits-1:0] found_offset,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [htlp_pkg::CapBits-1:0]    capacity_in_use
);
  import htlp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_HASH = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]            state;
  logic [CapBits-1:0]    cap_reg;
  logic [CapBits-1:0]    cap;
  logic                  act;
  logic [KeyBits-1:0]    key;
  logic [LenBits-1:0]    len;
  logic [OffsetBits-1:0] off;
  logic [SlotBits-1:0]   idx;
  logic [CapBits-1:0]    visits;
  logic [StatusBits-1:0] res_status;
  logic [OffsetBits-1:0] res_off;
  logic                  hash_start;
  logic                  hash_done;
  logic [SlotBits-1:0]   home;
  logic                  rd_occ;
  entry_t                rd_data;
  wr_req_t               wr;
  logic [LenBits-1:0]    len_sat;
  logic [KeyBits-1:0]    kmask;
  logic                  match;
  logic                  last_idx;

  always_comb begin
    len_sat = (key_length > MaxKeyBytes) ? MaxKeyBytes : key_length;
    if (len_sat[3]) begin
      kmask = '1;
    end else begin
      kmask = ~({KeyBits{1'b1}} << {len_sat[2:0], 3'b000});
    end
    if (cap_reg == '0) begin
      cap = CapBits'(1);
    end else if (cap_reg > CapBits'(TableDepth)) begin
      cap = CapBits'(TableDepth);
    end else begin
      cap = cap_reg;
    end
  end

  assign in_stall   = (state != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign hash_start = in_valid && !in_stall;
  assign match      = (rd_data.len == len) && (rd_data.key == key);
  assign last_idx   = ({1'b0, idx} + 1'b1) == cap;

  htlp_hash u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (hash_start),
    .key   (key_bytes & kmask),
    .len   (len_sat),
    .cap   (cap),
    .done  (hash_done),
    .home  (home)
  );

  htlp_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (idx),
    .rd_occ  (rd_occ),
    .rd_data (rd_data),
    .wr      (wr)
  );

  always_comb begin
    wr          = '0;
    wr.addr     = idx;
    wr.data.key = key;
    wr.data.len = len;
    wr.data.offset = off;
    if (state == S_CMP && act == ACT_PUT) begin
      if (!rd_occ) begin
        wr.en = 1'b1;
      end else if (match) begin
        wr.en       = 1'b1;
        wr.occ_only = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cap_reg   <= CapReset;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_reg <= capacity_in_use;
      end
      if (state == S_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (hash_start) begin
            act   <= action;
            key   <= key_bytes & kmask;
            len   <= len_sat;
            off   <= new_offset;
            state <= S_HASH;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            idx    <= home;
            visits <= '0;
            state  <= S_RD;
          end
        end
        S_RD: begin
          if (visits == cap) begin
            res_status <= ST_FULL;
            res_off    <= '0;
            state      <= S_OUT;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          res_off <= '0;
          priority if (!rd_occ) begin
            res_status <= (act == ACT_PUT) ? ST_INSERTED : ST_MISS;
            state      <= S_OUT;
          end else if (match) begin
            res_status <= (act == ACT_PUT) ? ST_UPDATED : ST_HIT;
            if (act == ACT_GET) begin
              res_off <= rd_data.offset;
            end
            state <= S_OUT;
          end else begin
            idx    <= last_idx ? '0 : idx + 1'b1;
            visits <= visits + 1'b1;
            state  <= S_RD;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            status       <= res_status;
            found_offset <= res_off;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
